### sv/tlvp_pkg.sv
`default_nettype none

package tlvp_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam logic [7:0]  MAX_RECORDS_RESET = 8'd10;

    // parser phases
    localparam logic [2:0] PH_COUNT = 3'd0;
    localparam logic [2:0] PH_INDEX = 3'd1;
    localparam logic [2:0] PH_BLEN  = 3'd2;
    localparam logic [2:0] PH_FID   = 3'd3;
    localparam logic [2:0] PH_FLEN  = 3'd4;
    localparam logic [2:0] PH_FDATA = 3'd5;
    localparam logic [2:0] PH_SKIP  = 3'd6;
    localparam logic [2:0] PH_DONE  = 3'd7;

    // field ids on the wire
    localparam logic [7:0] ID_SURNAME    = 8'h01;
    localparam logic [7:0] ID_NAME       = 8'h02;
    localparam logic [7:0] ID_PATRONYMIC = 8'h03;
    localparam logic [7:0] ID_AGE        = 8'h04;
    localparam logic [7:0] ID_SEX        = 8'h05;
    localparam logic [7:0] ID_USAGE      = 8'h06;

    // field classes, decoded in the front end
    localparam logic [2:0] CLS_OTHER = 3'd0;
    localparam logic [2:0] CLS_TEXT  = 3'd1;
    localparam logic [2:0] CLS_AGE   = 3'd2;
    localparam logic [2:0] CLS_SEX   = 3'd3;
    localparam logic [2:0] CLS_USAGE = 3'd4;

    // event codes
    localparam logic [3:0] EV_NONE    = 4'd0;
    localparam logic [3:0] EV_COUNT   = 4'd1;
    localparam logic [3:0] EV_START   = 4'd2;
    localparam logic [3:0] EV_THDR    = 4'd3;
    localparam logic [3:0] EV_TCHAR   = 4'd4;
    localparam logic [3:0] EV_AGE     = 4'd5;
    localparam logic [3:0] EV_SEX     = 4'd6;
    localparam logic [3:0] EV_USAGE   = 4'd7;
    localparam logic [3:0] EV_SKIPPED = 4'd8;
    localparam logic [3:0] EV_FERR    = 4'd9;
    localparam logic [3:0] EV_TRUNC   = 4'd10;
    localparam logic [3:0] EV_EMPTY   = 4'd11;

    localparam int unsigned BYTE_BITS = 8;

    typedef struct packed {
        logic [7:0] data;
        logic       eoi;
        logic [2:0] fclass;
        logic [1:0] kind;
        logic       zero;
    } q_entry_t;

endpackage

`default_nettype wire

### sv/record_tlv_stream_parser.sv
// An accepted input beat goes through the queue and the output register to m_.
// Throughput: one beat per cycle unless m_ready stalls; parser state updates
// once per beat in the back end; a QUEUE_DEPTH-entry queue buffers the input.
// Reset (aresetn low, synchronous): queue emptied, output invalid, parser
// back to expecting the count byte, max_records set to 10.
`default_nettype none

module record_tlv_stream_parser import tlvp_pkg::*; #(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_end_of_input,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [3:0]       m_event_res,
    output logic [1:0]       m_field_kind,
    output logic [15:0]      m_value,
    output logic [7:0]       m_record_index,
    output logic [7:0]       m_record_slot,
    output logic             m_record_end,
    output logic             m_parse_done,
    output logic             m_over_limit
);

    logic     q_valid, q_ready;
    q_entry_t q_entry;

    tlvp_front #(
        .DEPTH (DEPTH)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_end_of_input (s_end_of_input),
        .q_valid        (q_valid),
        .q_ready        (q_ready),
        .q_entry        (q_entry)
    );

    tlvp_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .q_valid        (q_valid),
        .q_ready        (q_ready),
        .q_entry        (q_entry),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_event_res    (m_event_res),
        .m_field_kind   (m_field_kind),
        .m_value        (m_value),
        .m_record_index (m_record_index),
        .m_record_slot  (m_record_slot),
        .m_record_end   (m_record_end),
        .m_parse_done   (m_parse_done),
        .m_over_limit   (m_over_limit)
    );

endmodule

`default_nettype wire

### sv/tlvp_front.sv
`default_nettype none

module tlvp_front import tlvp_pkg::*; #(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_data_byte,
    input  wire logic       s_end_of_input,
    output logic            q_valid,
    input  wire logic       q_ready,
    output q_entry_t        q_entry
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    q_entry_t         entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    q_entry_t         in_entry;
    logic             push, pop;

    // classify the incoming beat
    always_comb begin
        in_entry        = '0;
        in_entry.data   = s_data_byte;
        in_entry.eoi    = s_end_of_input;
        in_entry.zero   = (s_data_byte == 8'd0);
        in_entry.fclass = CLS_OTHER;
        unique case (s_data_byte)
            ID_SURNAME, ID_NAME, ID_PATRONYMIC: begin
                in_entry.fclass = CLS_TEXT;
                in_entry.kind   = 2'(s_data_byte - ID_SURNAME);
            end
            ID_AGE:   in_entry.fclass = CLS_AGE;
            ID_SEX:   in_entry.fclass = CLS_SEX;
            ID_USAGE: in_entry.fclass = CLS_USAGE;
            default:  in_entry.fclass = CLS_OTHER;
        endcase
    end

    assign s_ready = (count_reg != CNT_W'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_entry = entry_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_entry;
        end
    end

endmodule

`default_nettype wire

### sv/tlvp_back.sv
`default_nettype none

module tlvp_back import tlvp_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data,
    input  wire logic        q_valid,
    output logic             q_ready,
    input  wire q_entry_t    q_entry,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [3:0]       m_event_res,
    output logic [1:0]       m_field_kind,
    output logic [15:0]      m_value,
    output logic [7:0]       m_record_index,
    output logic [7:0]       m_record_slot,
    output logic             m_record_end,
    output logic             m_parse_done,
    output logic             m_over_limit
);

    logic [7:0] max_rec_reg;
    logic [2:0] phase_reg,     phase_next;
    logic [7:0] rec_exp_reg,   rec_exp_next;
    logic [7:0] rec_read_reg,  rec_read_next;
    logic [7:0] blk_rem_reg,   blk_rem_next;
    logic [7:0] cur_idx_reg,   cur_idx_next;
    logic [2:0] fclass_reg,    fclass_next;
    logic [1:0] fkind_reg,     fkind_next;
    logic [7:0] frem_reg,      frem_next;
    logic [1:0] foff_reg,      foff_next;
    logic [7:0] usage_low_reg, usage_low_next;

    logic       out_valid_reg;
    logic [3:0] ev_reg;
    logic [1:0] kind_reg;
    logic [15:0] val_reg;
    logic [7:0] idx_reg, slot_reg;
    logic       rend_reg, done_reg, over_reg;

    logic [3:0]  ev;
    logic [1:0]  kind;
    logic [15:0] val;
    logic [7:0]  slot;
    logic        rend, over;
    logic [7:0]  b, blk_dec, frem_dec, rr_inc;
    logic        last, close;
    logic [2:0]  close_phase;
    logic        pop;

    assign pop     = q_valid && (!out_valid_reg || m_ready);
    assign q_ready = !out_valid_reg || m_ready;

    assign b        = q_entry.data;
    assign blk_dec  = (blk_rem_reg == 8'd0) ? 8'd0 : blk_rem_reg - 8'd1;
    assign last     = (blk_dec == 8'd0);
    assign frem_dec = (frem_reg == 8'd0) ? 8'd0 : frem_reg - 8'd1;
    assign rr_inc   = rec_read_reg + 8'd1;
    assign close_phase = (rr_inc >= rec_exp_reg || rr_inc >= max_rec_reg) ? PH_DONE : PH_INDEX;

    always_comb begin
        phase_next     = phase_reg;
        rec_exp_next   = rec_exp_reg;
        rec_read_next  = rec_read_reg;
        blk_rem_next   = blk_rem_reg;
        cur_idx_next   = cur_idx_reg;
        fclass_next    = fclass_reg;
        fkind_next     = fkind_reg;
        frem_next      = frem_reg;
        foff_next      = foff_reg;
        usage_low_next = usage_low_reg;
        ev    = EV_NONE;
        kind  = 2'd0;
        val   = 16'd0;
        slot  = rec_read_reg;
        over  = 1'b0;
        close = 1'b0;

        if (phase_reg == PH_DONE) begin
            phase_next = PH_DONE;
        end else if (q_entry.eoi) begin
            ev         = (phase_reg == PH_COUNT) ? EV_EMPTY : EV_TRUNC;
            phase_next = PH_DONE;
        end else begin
            unique case (phase_reg)
                PH_COUNT: begin
                    ev            = EV_COUNT;
                    val           = {8'd0, b};
                    over          = (b > max_rec_reg);
                    rec_exp_next  = b;
                    rec_read_next = 8'd0;
                    slot          = 8'd0;
                    phase_next    = (q_entry.zero || max_rec_reg == 8'd0) ? PH_DONE : PH_INDEX;
                end
                PH_INDEX: begin
                    cur_idx_next = b;
                    phase_next   = PH_BLEN;
                end
                PH_BLEN: begin
                    ev           = EV_START;
                    val          = {8'd0, b};
                    blk_rem_next = b;
                    if (q_entry.zero) begin
                        close = 1'b1;
                    end else begin
                        phase_next = PH_FID;
                    end
                end
                PH_FID: begin
                    blk_rem_next = blk_dec;
                    fclass_next  = q_entry.fclass;
                    fkind_next   = q_entry.kind;
                    if (last) begin
                        ev    = EV_FERR;
                        val   = {8'd0, b};
                        close = 1'b1;
                    end else begin
                        phase_next = PH_FLEN;
                    end
                end
                PH_FLEN: begin
                    blk_rem_next = blk_dec;
                    if (b > blk_dec) begin
                        ev  = EV_FERR;
                        val = {8'd0, b};
                        if (last) begin
                            close = 1'b1;
                        end else begin
                            phase_next = PH_SKIP;
                        end
                    end else begin
                        frem_next = b;
                        foff_next = 2'd0;
                        if (fclass_reg == CLS_TEXT) begin
                            ev   = EV_THDR;
                            kind = fkind_reg;
                            val  = {8'd0, b};
                        end
                        if (q_entry.zero) begin
                            if (last) begin
                                close = 1'b1;
                            end else begin
                                phase_next = PH_FID;
                            end
                        end else begin
                            phase_next = PH_FDATA;
                        end
                    end
                end
                PH_FDATA: begin
                    blk_rem_next = blk_dec;
                    if (fclass_reg == CLS_TEXT) begin
                        ev   = EV_TCHAR;
                        kind = fkind_reg;
                        val  = {8'd0, b};
                    end else if (fclass_reg == CLS_AGE && foff_reg == 2'd0) begin
                        ev  = EV_AGE;
                        val = {8'd0, b};
                    end else if (fclass_reg == CLS_SEX && foff_reg == 2'd0) begin
                        ev  = EV_SEX;
                        val = {8'd0, b};
                    end else if (fclass_reg == CLS_USAGE && foff_reg == 2'd0
                                 && frem_reg >= 8'd2) begin
                        usage_low_next = b;
                    end else if (fclass_reg == CLS_USAGE && foff_reg == 2'd1) begin
                        ev  = EV_USAGE;
                        val = {b, usage_low_reg};
                    end else begin
                        ev  = EV_SKIPPED;
                        val = {8'd0, b};
                    end
                    frem_next = frem_dec;
                    // offset only matters as 0, 1 or past that
                    foff_next = (foff_reg == 2'd2) ? 2'd2 : foff_reg + 2'd1;
                    if (last) begin
                        close = 1'b1;
                    end else if (frem_dec == 8'd0) begin
                        phase_next = PH_FID;
                    end
                end
                PH_SKIP: begin
                    blk_rem_next = blk_dec;
                    ev           = EV_SKIPPED;
                    val          = {8'd0, b};
                    if (last) begin
                        close = 1'b1;
                    end
                end
                default: begin
                    phase_next = PH_DONE;
                end
            endcase
        end

        rend = close;
        if (close) begin
            rec_read_next = rr_inc;
            phase_next    = close_phase;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_rec_reg   <= MAX_RECORDS_RESET;
            phase_reg     <= PH_COUNT;
            rec_exp_reg   <= '0;
            rec_read_reg  <= '0;
            blk_rem_reg   <= '0;
            cur_idx_reg   <= '0;
            fclass_reg    <= CLS_OTHER;
            fkind_reg     <= '0;
            frem_reg      <= '0;
            foff_reg      <= '0;
            usage_low_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                max_rec_reg <= cfg_wr_data;
            end
            if (pop) begin
                phase_reg     <= phase_next;
                rec_exp_reg   <= rec_exp_next;
                rec_read_reg  <= rec_read_next;
                blk_rem_reg   <= blk_rem_next;
                cur_idx_reg   <= cur_idx_next;
                fclass_reg    <= fclass_next;
                fkind_reg     <= fkind_next;
                frem_reg      <= frem_next;
                foff_reg      <= foff_next;
                usage_low_reg <= usage_low_next;
            end
            if (pop) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            ev_reg   <= ev;
            kind_reg <= kind;
            val_reg  <= val;
            idx_reg  <= cur_idx_next;
            slot_reg <= slot;
            rend_reg <= rend;
            done_reg <= (phase_next == PH_DONE);
            over_reg <= over;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_event_res    = ev_reg;
    assign m_field_kind   = kind_reg;
    assign m_value        = val_reg;
    assign m_record_index = idx_reg;
    assign m_record_slot  = slot_reg;
    assign m_record_end   = rend_reg;
    assign m_parse_done   = done_reg;
    assign m_over_limit   = over_reg;

endmodule

`default_nettype wire

### sv/tlvp_checker.sv
`default_nettype none

module tlvp_checker import tlvp_pkg::*; (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        cfg_wr_en,
    input wire logic [7:0]  cfg_wr_data,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic [7:0]  s_data_byte,
    input wire logic        s_end_of_input,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [3:0]  m_event_res,
    input wire logic [1:0]  m_field_kind,
    input wire logic [15:0] m_value,
    input wire logic [7:0]  m_record_index,
    input wire logic [7:0]  m_record_slot,
    input wire logic        m_record_end,
    input wire logic        m_parse_done,
    input wire logic        m_over_limit
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_event_res) && $stable(m_value))
        else $error("result beat changed while stalled");

    // end of stream always finishes parsing
    a_eoi_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_event_res == EV_EMPTY || m_event_res == EV_TRUNC) |-> m_parse_done)
        else $error("empty or truncated without parse_done");

    a_over_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_over_limit |-> m_event_res == EV_COUNT)
        else $error("over_limit outside count beat");

    a_kind_text: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_field_kind != 2'd0 |->
            (m_event_res == EV_THDR || m_event_res == EV_TCHAR))
        else $error("field_kind set on non-text beat");

    // a zero-length non-text field can close a record with event none
    a_none_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_event_res == EV_NONE || m_event_res == EV_EMPTY
                    || m_event_res == EV_TRUNC) |-> m_value == 16'd0)
        else $error("value on beat without payload");

endmodule

bind record_tlv_stream_parser tlvp_checker u_tlvp_checker (.*);

`default_nettype wire
